>>> rtl/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg
// Shared types and constants of the styled line rasterizer.
// ----------------------------------------------------------------------------
package slr_pkg;

    localparam int PIX_COORD_BITS = 16;
    localparam int ADDR_BITS      = 20;
    localparam int COLOUR_BITS    = 8;
    localparam int SCREEN_BITS    = 11;
    localparam int STYLE_BITS     = 2;
    localparam int DIR_BITS       = 2;
    localparam int PHASE_BITS     = 3;
    localparam int S_TDATA_BITS   = 80;
    localparam int M_TDATA_BITS   = 64;

    localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = 11'd320;
    localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 11'd200;

    localparam logic [PHASE_BITS-1:0] DASH_PHASE_LAST = 3'd4;

    localparam logic [STYLE_BITS-1:0] STYLE_DOTTED = 2'd0;
    localparam logic [STYLE_BITS-1:0] STYLE_DASHED = 2'd1;
    localparam logic [STYLE_BITS-1:0] STYLE_SOLID  = 2'd2;

    localparam logic [DIR_BITS-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_BITS-1:0] DIR_POS  = 2'd1;
    localparam logic [DIR_BITS-1:0] DIR_NEG  = 2'd3;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_COORD_BITS-1:0] x;
        logic [PIX_COORD_BITS-1:0] y;
        logic [COLOUR_BITS-1:0]    colour;
        logic                      keep;
        logic                      last;
    } pixel_t;

endpackage

>>> rtl/slr_step_unit.sv
// ----------------------------------------------------------------------------
// slr_step_unit
// Bresenham walker: loads a line on a start request and steps one pixel per
// step request while busy, presenting the current pixel and its style keep bit.
// ----------------------------------------------------------------------------
module slr_step_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 accept,
    input  logic                                 opcode,
    input  logic [slr_pkg::PIX_COORD_BITS-1:0]   start_x,
    input  logic [slr_pkg::PIX_COORD_BITS-1:0]   start_y,
    input  logic [slr_pkg::PIX_COORD_BITS-1:0]   end_x,
    input  logic [slr_pkg::PIX_COORD_BITS-1:0]   end_y,
    input  logic [slr_pkg::STYLE_BITS-1:0]       style,
    input  logic [slr_pkg::COLOUR_BITS-1:0]      colour,
    output logic                                 emit,
    output slr_pkg::pixel_t                      pixel
);
    import slr_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic [CW-1:0]          cur_x_reg, cur_x_next;
    logic [CW-1:0]          cur_y_reg, cur_y_next;
    logic [CW:0]            error_acc_reg, error_acc_next;
    logic [CW-1:0]          major_len_reg, major_len_next;
    logic [CW-1:0]          minor_len_reg, minor_len_next;
    logic [CW-1:0]          steps_left_reg, steps_left_next;
    logic [DIR_BITS-1:0]    diag_x_reg, diag_x_next;
    logic [DIR_BITS-1:0]    diag_y_reg, diag_y_next;
    logic [DIR_BITS-1:0]    straight_x_reg, straight_x_next;
    logic [DIR_BITS-1:0]    straight_y_reg, straight_y_next;
    logic                   parity_reg, parity_next;
    logic [PHASE_BITS-1:0]  dash_phase_reg, dash_phase_next;
    logic [STYLE_BITS-1:0]  line_style_reg, line_style_next;
    logic [COLOUR_BITS-1:0] line_colour_reg, line_colour_next;
    logic                   busy_reg, busy_next;

    logic [CW-1:0]       x0, y0, x1, y1, adx, ady;
    logic [DIR_BITS-1:0] sx, sy;
    logic [CW:0]         err_sum;
    logic                is_last, keep;

    function automatic logic [DIR_BITS-1:0] dir_code(input logic [CW-1:0] a,
                                                      input logic [CW-1:0] b);
        logic [DIR_BITS-1:0] code;
        if (b > a) begin
            code = DIR_POS;
        end else if (b < a) begin
            code = DIR_NEG;
        end else begin
            code = DIR_NONE;
        end
        return code;
    endfunction

    function automatic logic [CW-1:0] step_coord(input logic [CW-1:0] coord,
                                                  input logic [DIR_BITS-1:0] code);
        logic [CW-1:0] res;
        case (code)
            DIR_POS: res = coord + CW'(1);
            DIR_NEG: res = coord - CW'(1);
            default: res = coord;
        endcase
        return res;
    endfunction

    assign x0 = start_x[CW-1:0];
    assign y0 = start_y[CW-1:0];
    assign x1 = end_x[CW-1:0];
    assign y1 = end_y[CW-1:0];
    assign adx = (x1 >= x0) ? x1 - x0 : x0 - x1;
    assign ady = (y1 >= y0) ? y1 - y0 : y0 - y1;
    assign sx = dir_code(x0, x1);
    assign sy = dir_code(y0, y1);

    assign is_last = (steps_left_reg == '0);
    assign err_sum = error_acc_reg + {1'b0, minor_len_reg};

    always_comb begin
        case (line_style_reg)
            STYLE_DOTTED: keep = !parity_reg;
            STYLE_DASHED: keep = (dash_phase_reg != '0);
            default:      keep = 1'b1;
        endcase
    end

    assign emit = accept && (opcode == OP_STEP) && busy_reg;

    assign pixel.x      = PIX_COORD_BITS'(cur_x_reg);
    assign pixel.y      = PIX_COORD_BITS'(cur_y_reg);
    assign pixel.colour = line_colour_reg;
    assign pixel.keep   = keep;
    assign pixel.last   = is_last;

    always_comb begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        error_acc_next   = error_acc_reg;
        major_len_next   = major_len_reg;
        minor_len_next   = minor_len_reg;
        steps_left_next  = steps_left_reg;
        diag_x_next      = diag_x_reg;
        diag_y_next      = diag_y_reg;
        straight_x_next  = straight_x_reg;
        straight_y_next  = straight_y_reg;
        parity_next      = parity_reg;
        dash_phase_next  = dash_phase_reg;
        line_style_next  = line_style_reg;
        line_colour_next = line_colour_reg;
        busy_next        = busy_reg;
        if (accept && (opcode == OP_START)) begin
            diag_x_next = sx;
            diag_y_next = sy;
            if (adx > ady) begin
                major_len_next  = adx;
                minor_len_next  = ady;
                straight_x_next = sx;
                straight_y_next = DIR_NONE;
                error_acc_next  = {2'b00, adx[CW-1:1]};
                steps_left_next = adx;
            end else begin
                major_len_next  = ady;
                minor_len_next  = adx;
                straight_x_next = DIR_NONE;
                straight_y_next = sy;
                error_acc_next  = {2'b00, ady[CW-1:1]};
                steps_left_next = ady;
            end
            cur_x_next       = x0;
            cur_y_next       = y0;
            parity_next      = 1'b0;
            dash_phase_next  = '0;
            line_style_next  = style;
            line_colour_next = colour;
            busy_next        = 1'b1;
        end else if (emit) begin
            if (err_sum >= {1'b0, major_len_reg}) begin
                error_acc_next = err_sum - {1'b0, major_len_reg};
                cur_x_next     = step_coord(cur_x_reg, diag_x_reg);
                cur_y_next     = step_coord(cur_y_reg, diag_y_reg);
            end else begin
                error_acc_next = err_sum;
                cur_x_next     = step_coord(cur_x_reg, straight_x_reg);
                cur_y_next     = step_coord(cur_y_reg, straight_y_reg);
            end
            parity_next     = !parity_reg;
            dash_phase_next = (dash_phase_reg == DASH_PHASE_LAST) ? '0
                              : dash_phase_reg + PHASE_BITS'(1);
            if (is_last) begin
                busy_next = 1'b0;
            end else begin
                steps_left_next = steps_left_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            error_acc_reg   <= '0;
            major_len_reg   <= '0;
            minor_len_reg   <= '0;
            steps_left_reg  <= '0;
            diag_x_reg      <= DIR_NONE;
            diag_y_reg      <= DIR_NONE;
            straight_x_reg  <= DIR_NONE;
            straight_y_reg  <= DIR_NONE;
            parity_reg      <= 1'b0;
            dash_phase_reg  <= '0;
            line_style_reg  <= STYLE_SOLID;
            line_colour_reg <= '0;
            busy_reg        <= 1'b0;
        end else begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            error_acc_reg   <= error_acc_next;
            major_len_reg   <= major_len_next;
            minor_len_reg   <= minor_len_next;
            steps_left_reg  <= steps_left_next;
            diag_x_reg      <= diag_x_next;
            diag_y_reg      <= diag_y_next;
            straight_x_reg  <= straight_x_next;
            straight_y_reg  <= straight_y_next;
            parity_reg      <= parity_next;
            dash_phase_reg  <= dash_phase_next;
            line_style_reg  <= line_style_next;
            line_colour_reg <= line_colour_next;
            busy_reg        <= busy_next;
        end
    end

endmodule

>>> rtl/slr_pixel_stage.sv
// ----------------------------------------------------------------------------
// slr_pixel_stage
// Screen clipping and frame offset (row times width plus column) of a pixel.
// ----------------------------------------------------------------------------
module slr_pixel_stage (
    input  slr_pkg::pixel_t                   pixel,
    input  logic [slr_pkg::SCREEN_BITS-1:0]   screen_width,
    input  logic [slr_pkg::SCREEN_BITS-1:0]   screen_height,
    output logic [slr_pkg::ADDR_BITS-1:0]     address,
    output logic                              write_enable
);
    import slr_pkg::*;

    localparam int PROD_BITS = PIX_COORD_BITS + SCREEN_BITS;

    logic [PROD_BITS-1:0] row_base;
    logic [PROD_BITS-1:0] offset;
    logic                 in_screen;

    assign in_screen = (pixel.x < PIX_COORD_BITS'(screen_width))
                    && (pixel.y < PIX_COORD_BITS'(screen_height));
    assign row_base = PROD_BITS'(pixel.y) * PROD_BITS'(screen_width);
    assign offset   = row_base + PROD_BITS'(pixel.x);

    assign write_enable = in_screen && pixel.keep;
    assign address      = write_enable ? offset[ADDR_BITS-1:0] : '0;

endmodule

>>> rtl/styled_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// styled_line_rasterizer_top
// Bresenham line rasterizer with dotted, dashed and solid styles.
// ----------------------------------------------------------------------------
// A start request loads both endpoints, the style and the colour and yields no
// pixel; it restarts any line in progress. Each step request while a line is
// active yields one pixel, one request per clock sustained while the master side
// is not stalled. The pixel of a taken step request is captured in the s1
// register while the walker updates its error accumulator, then clipped, given
// its frame offset by the row-times-width multiplier and registered on the master
// side. A line of major length L takes L+1 step requests; steps sent with no active
// line are taken and dropped. Write the screen size registers only while idle.
module styled_line_rasterizer_top #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_addr,
    input  logic [slr_pkg::SCREEN_BITS-1:0]      cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // start_x, start_y, end_x, end_y, style, colour, zero pad
    input  logic [slr_pkg::S_TDATA_BITS-1:0]     s_tdata,
    // opcode
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // pixel_x, pixel_y, pixel_address, pixel_colour, write_enable, zero pad
    output logic [slr_pkg::M_TDATA_BITS-1:0]     m_tdata,
    output logic                                 m_tlast
);
    import slr_pkg::*;

    logic [SCREEN_BITS-1:0] screen_width_reg;
    logic [SCREEN_BITS-1:0] screen_height_reg;

    logic                   accept;
    logic                   advance;
    logic                   emit;
    pixel_t                 walk_pixel;

    logic                   s1_valid_reg;
    pixel_t                 s1_pixel_reg;

    logic [ADDR_BITS-1:0]   pix_address;
    logic                   pix_we;

    logic                   m_valid_reg;
    logic [PIX_COORD_BITS-1:0] m_x_reg, m_y_reg;
    logic [ADDR_BITS-1:0]   m_address_reg;
    logic [COLOUR_BITS-1:0] m_colour_reg;
    logic                   m_we_reg;
    logic                   m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= SCREEN_WIDTH_RESET;
            screen_height_reg <= SCREEN_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wdata;
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    slr_step_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .opcode  (s_tuser),
        .start_x (s_tdata[15:0]),
        .start_y (s_tdata[31:16]),
        .end_x   (s_tdata[47:32]),
        .end_y   (s_tdata[63:48]),
        .style   (s_tdata[65:64]),
        .colour  (s_tdata[73:66]),
        .emit    (emit),
        .pixel   (walk_pixel)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            s1_pixel_reg <= walk_pixel;
        end
    end

    slr_pixel_stage u_pixel (
        .pixel         (s1_pixel_reg),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .address       (pix_address),
        .write_enable  (pix_we)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_x_reg       <= s1_pixel_reg.x;
            m_y_reg       <= s1_pixel_reg.y;
            m_address_reg <= pix_address;
            m_colour_reg  <= s1_pixel_reg.colour;
            m_we_reg      <= pix_we;
            m_last_reg    <= s1_pixel_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_we_reg, m_colour_reg, m_address_reg, m_y_reg, m_x_reg};
    assign m_tlast  = m_last_reg;

endmodule

>>> rtl/slr_checker.sv
// ----------------------------------------------------------------------------
// slr_checker
// Port-level checks of the styled line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module slr_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [slr_pkg::M_TDATA_BITS-1:0]  m_tdata,
    input logic                              m_tlast
);
    import slr_pkg::*;

    // hold a stalled pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled pixel changed");

    // drop the address of a pixel that is not written
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[60] == 1'b0) |-> (m_tdata[51:32] == '0))
        else $error("address set on a masked pixel");

    // an empty output side never blocks requests
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request blocked with empty output");

    // no pixel right after reset
    assert property (@(posedge aclk)
        ($past(aresetn) == 1'b0) |-> !m_tvalid)
        else $error("pixel shown after reset");

endmodule

bind styled_line_rasterizer_top slr_checker u_slr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
